/* rtl/shabc_pkg.sv */
// Shared types, constants and round functions for the SHA-256 block compress unit.
// Has no dependencies; imported by every module of the unit.
package shabc_pkg;

   localparam int HashWords  = 8;
   localparam int BlockWords = 16;
   localparam int Rounds     = 64;

   // One message word as it travels from the front end to the compression core.
   typedef struct packed {
      logic [31:0] word;
      logic        restart;
   } qword_type;

   localparam logic [31:0] IV_TABLE [HashWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] K_TABLE [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      choose = (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
      majority = (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

/* rtl/shabc_front.sv */
// Front end of the SHA-256 block compress unit: accepts message words and tags them.
// Depends on shabc_pkg for the queue entry type.
module shabc_front import shabc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_message_word,
   input  logic        req_new_message,
   output logic        q_push,
   output qword_type   q_wdata,
   input  logic        q_full
);

   logic [3:0] count_ff;
   logic [3:0] count_in;

   // The restart flag only counts on the first word of a block.
   assign req_full        = q_full;
   assign q_push          = req_push & ~q_full;
   assign q_wdata.word    = req_message_word;
   assign q_wdata.restart = (count_ff == 4'd0) & req_new_message;

   assign count_in = q_push ? count_ff + 4'd1 : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/shabc_fifo.sv */
// Short word queue between the front end and the compression core.
// Depends on shabc_pkg for the entry type.
module shabc_fifo import shabc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  qword_type wdata,
   output logic      full,
   input  logic      pop,
   output qword_type rdata,
   output logic      valid
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   qword_type       mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/shabc_core.sv */
// Compression core: schedule window, one SHA-256 round per cycle if fed, final add.
// Depends on shabc_pkg for constants, round functions and the queue entry type.
module shabc_core import shabc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  qword_type    q_data,
   input  logic         q_valid,
   output logic         q_pop,
   output logic         fin_valid,
   input  logic         fin_ready,
   output logic [255:0] fin_digest
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_EXPAND = 4'b0100,
      ST_FINISH = 4'b1000
   } core_state_type;

   core_state_type state_ff, state_in;
   logic [5:0]     rnd_ff, rnd_in;
   logic [31:0]    chain_ff [HashWords];
   logic [31:0]    chain_in [HashWords];
   logic [31:0]    var_ff   [HashWords];
   logic [31:0]    var_in   [HashWords];
   logic [31:0]    win_ff   [BlockWords];
   logic [31:0]    win_in   [BlockWords];
   logic [31:0]    base     [HashWords];
   logic [31:0]    rnd_vars [HashWords];
   logic [31:0]    sum      [HashWords];
   logic [31:0]    w_sched, w_cur, t1, t2;

   // The window holds the last sixteen schedule words, oldest at index zero.
   assign w_sched = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9]
                  + small_sigma1(win_ff[14]);
   assign w_cur   = (state_ff == ST_LOAD) ? q_data.word : w_sched;

   assign t1 = var_ff[7] + big_sigma1(var_ff[4]) + choose(var_ff[4], var_ff[5], var_ff[6])
             + K_TABLE[rnd_ff] + w_cur;
   assign t2 = big_sigma0(var_ff[0]) + majority(var_ff[0], var_ff[1], var_ff[2]);

   always_comb begin
      rnd_vars[0] = t1 + t2;
      rnd_vars[1] = var_ff[0];
      rnd_vars[2] = var_ff[1];
      rnd_vars[3] = var_ff[2];
      rnd_vars[4] = var_ff[3] + t1;
      rnd_vars[5] = var_ff[4];
      rnd_vars[6] = var_ff[5];
      rnd_vars[7] = var_ff[6];
      for (int i = 0; i < HashWords; i++) begin
         base[i] = q_data.restart ? IV_TABLE[i] : chain_ff[i];
         sum[i]  = chain_ff[i] + var_ff[i];
      end
   end

   assign fin_digest = {sum[0], sum[1], sum[2], sum[3], sum[4], sum[5], sum[6], sum[7]};

   always_comb begin
      state_in  = state_ff;
      rnd_in    = rnd_ff;
      chain_in  = chain_ff;
      var_in    = var_ff;
      win_in    = win_ff;
      q_pop     = 1'b0;
      fin_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Peek at the first word of the next block to pick the start value.
            if (q_valid) begin
               var_in   = base;
               chain_in = base;
               rnd_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               var_in = rnd_vars;
               for (int j = 0; j < BlockWords - 1; j++) begin
                  win_in[j] = win_ff[j + 1];
               end
               win_in[BlockWords - 1] = w_cur;
               rnd_in = rnd_ff + 6'd1;
               if (rnd_ff == 6'(BlockWords - 1)) begin
                  state_in = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            var_in = rnd_vars;
            for (int j = 0; j < BlockWords - 1; j++) begin
               win_in[j] = win_ff[j + 1];
            end
            win_in[BlockWords - 1] = w_cur;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'(Rounds - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            fin_valid = 1'b1;
            if (fin_ready) begin
               chain_in = sum;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         chain_ff <= IV_TABLE;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      var_ff <= var_in;
      win_ff <= win_in;
   end

endmodule

/* rtl/sha256_block_compress_unit.sv */
// SHA-256 block compress unit: sixteen message words in, one 256-bit digest out per block.
// Throughput: the compression core works on one block at a time, one round per cycle
// but waiting on the word queue in its load rounds; words are taken one per cycle
// until the word queue fills.
// Reset: synchronous, clears the word count, the queue and the core, drops any partial
// block and returns the chaining value to the SHA-256 initial hash values.
module sha256_block_compress_unit import shabc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_message_word,
   input  logic        req_new_message,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_digest_h0_h1,
   output logic [63:0] rsp_digest_h2_h3,
   output logic [63:0] rsp_digest_h4_h5,
   output logic [63:0] rsp_digest_h6_h7
);

   // Front end to queue.
   logic      fq_push;
   qword_type fq_wdata;
   logic      fq_full;

   // Queue to core.
   qword_type qc_data;
   logic      qc_valid;
   logic      qc_pop;

   // Core to result register.
   logic         fin_valid;
   logic         fin_ready;
   logic [255:0] fin_digest;
   logic         fin_fire;

   logic         out_valid_ff, out_valid_in;
   logic [255:0] out_data_ff;

   // The front end counts words within a block and tags the first one with its
   // restart flag; everything else about the block is the core's business.
   shabc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_message_word (req_message_word),
      .req_new_message  (req_new_message),
      .q_push           (fq_push),
      .q_wdata          (fq_wdata),
      .q_full           (fq_full)
   );

   // The queue lets the next block's words arrive while the core is still
   // running the expansion rounds of the current one.
   shabc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .wdata (fq_wdata),
      .full  (fq_full),
      .pop   (qc_pop),
      .rdata (qc_data),
      .valid (qc_valid)
   );

   shabc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .q_data     (qc_data),
      .q_valid    (qc_valid),
      .q_pop      (qc_pop),
      .fin_valid  (fin_valid),
      .fin_ready  (fin_ready),
      .fin_digest (fin_digest)
   );

   // The result register takes a new digest whenever it is empty or being
   // emptied by a transfer in the same cycle, so the core never waits on a
   // consumer that keeps up.
   assign fin_ready    = ~out_valid_ff | rsp_pop;
   assign fin_fire     = fin_valid & fin_ready;
   assign out_valid_in = fin_fire | (out_valid_ff & ~rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_fire) begin
         out_data_ff <= fin_digest;
      end
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_digest_h0_h1 = out_data_ff[255:192];
   assign rsp_digest_h2_h3 = out_data_ff[191:128];
   assign rsp_digest_h4_h5 = out_data_ff[127:64];
   assign rsp_digest_h6_h7 = out_data_ff[63:0];

`ifndef SYNTHESIS
   // A digest handed over by the core must show up as a waiting result.
   a_fin_shows: assert property (@(posedge clock) disable iff (reset)
      fin_fire |=> !rsp_empty)
      else $error("finished digest did not reach the result register");

   // A result transfer with nothing new from the core leaves the register empty.
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !fin_fire) |=> rsp_empty)
      else $error("result register still full after its transfer");
`endif

endmodule
